### design/rbd_pkg.sv
// Package for the 2x2 box downsampler: sizes, register indexes and line store types.
package rbd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int SIZE_W = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = $clog2(LINE_DEPTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } pair_sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    pair_sum_t lower;
    logic      last;
  } stage_t;

endpackage

### design/rgb_box_downsample_2x2.sv
// Top level: 2x2 box-filter downsampler with a line store of upper-row pair sums.
// A result word passes the stage-1 register (beside the registered line store read) and then the output register.
// Throughput: one pixel per cycle while in_stall is low; one result word per 2x2 block.
// The line store is one synchronous RAM (one write and one read port, registered read).
// Reset: clears position, pending pixel, valid flags; sizes return to 2.
// The line store is not cleared; every even row writes it before the odd row reads.
module rgb_box_downsample_2x2 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbd_pkg::SIZE_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic                           out_frame_end
);

  localparam logic [rbd_pkg::SIZE_W-1:0] MAX_W = rbd_pkg::SIZE_W'(rbd_pkg::MAX_WIDTH);
  localparam logic [rbd_pkg::SIZE_W-1:0] MAX_H = rbd_pkg::SIZE_W'(rbd_pkg::MAX_HEIGHT);
  localparam logic [rbd_pkg::SIZE_W-1:0] MIN_SZ = rbd_pkg::SIZE_W'(2);
  localparam logic [rbd_pkg::SIZE_W-1:0] ONE_SZ = rbd_pkg::SIZE_W'(1);

  logic [rbd_pkg::SIZE_W-1:0] src_w_r, src_h_r;
  logic [rbd_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [rbd_pkg::ROW_W-1:0]  row_r, row_nxt;
  rbd_pkg::pixel_t            pend_r, pend_nxt;

  rbd_pkg::pair_sum_t         mem [rbd_pkg::LINE_DEPTH];
  rbd_pkg::pair_sum_t         rd_data_r;

  logic                       s1_valid_r, s1_valid_nxt;
  rbd_pkg::stage_t            s1_r;

  logic                       out_valid_r, out_valid_nxt;
  rbd_pkg::pixel_t            out_pix_r;
  logic                       out_last_r;

  logic [rbd_pkg::SIZE_W-1:0] w_eff, h_eff, col_ext, row_ext;
  logic [rbd_pkg::COL_W-1:0]  col_eff;
  logic [rbd_pkg::ROW_W-1:0]  row_eff;
  logic [rbd_pkg::IDX_W-1:0]  idx;
  logic                       accept, out_free, wr_en, rd_en, last;
  rbd_pkg::pixel_t            pix;
  rbd_pkg::pair_sum_t         pair_sum;
  logic [9:0]                 tot_r, tot_g, tot_b;

  always_comb begin
    if (src_w_r < MIN_SZ) w_eff = MIN_SZ;
    else if (src_w_r > MAX_W) w_eff = MAX_W;
    else w_eff = src_w_r;
    if (src_h_r < MIN_SZ) h_eff = MIN_SZ;
    else if (src_h_r > MAX_H) h_eff = MAX_H;
    else h_eff = src_h_r;
  end

  always_comb begin
    if (rbd_pkg::SIZE_W'(col_r) >= w_eff) col_eff = rbd_pkg::COL_W'(w_eff - ONE_SZ);
    else col_eff = col_r;
    if (rbd_pkg::SIZE_W'(row_r) >= h_eff) row_eff = rbd_pkg::ROW_W'(h_eff - ONE_SZ);
    else row_eff = row_r;
    col_ext = rbd_pkg::SIZE_W'(col_eff);
    row_ext = rbd_pkg::SIZE_W'(row_eff);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign pix  = '{r: in_red_in, g: in_green_in, b: in_blue_in};
  assign idx  = rbd_pkg::IDX_W'(col_eff >> 1);

  assign pair_sum.r = 9'(pend_r.r) + 9'(pix.r);
  assign pair_sum.g = 9'(pend_r.g) + 9'(pix.g);
  assign pair_sum.b = 9'(pend_r.b) + 9'(pix.b);

  assign wr_en = accept && col_eff[0] && !row_eff[0];
  assign rd_en = accept && col_eff[0] && row_eff[0];
  assign last  = ((col_ext >> 1) == ((w_eff >> 1) - ONE_SZ)) &&
                 ((row_ext >> 1) == ((h_eff >> 1) - ONE_SZ));

  // position and pending left pixel
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (accept) begin
      if (!col_eff[0] && (col_ext + ONE_SZ < w_eff)) pend_nxt = pix;
      if (col_ext + ONE_SZ >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_ext + ONE_SZ >= h_eff) ? '0 : row_eff + rbd_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_eff + rbd_pkg::COL_W'(1);
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= MIN_SZ;
      src_h_r <= MIN_SZ;
      col_r   <= '0;
      row_r   <= '0;
      pend_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rbd_pkg::REG_SOURCE_WIDTH) begin
        src_w_r <= cfg_data;
        col_r   <= '0;
        row_r   <= '0;
      end else if (cfg_index == rbd_pkg::REG_SOURCE_HEIGHT) begin
        src_h_r <= cfg_data;
        col_r   <= '0;
        row_r   <= '0;
      end
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (wr_en) mem[idx] <= pair_sum;
    if (rd_en) rd_data_r <= mem[idx];
  end

  // stage 1: lower pair sum waits for the upper read
  always_comb begin
    if (accept) s1_valid_nxt = rd_en;
    else if (out_free) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) s1_r <= '{lower: pair_sum, last: last};
  end

  assign tot_r = 10'(rd_data_r.r) + 10'(s1_r.lower.r);
  assign tot_g = 10'(rd_data_r.g) + 10'(s1_r.lower.g);
  assign tot_b = 10'(rd_data_r.b) + 10'(s1_r.lower.b);

  // output register
  assign out_valid_nxt = out_free ? s1_valid_r : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pix_r  <= '{r: tot_r[9:2], g: tot_g[9:2], b: tot_b[9:2]};
      out_last_r <= s1_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r.r;
  assign out_green_out = out_pix_r.g;
  assign out_blue_out  = out_pix_r.b;
  assign out_frame_end = out_last_r;

endmodule

### design/rbd_checker.sv
// Port-level checker for the 2x2 box downsampler, bound to the top level.
module rbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic       out_frame_end
);

  // no word out of reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
    $stable(out_green_out) && $stable(out_blue_out) && $stable(out_frame_end))
    else $error("stalled result word changed");

  // a fresh result word follows an accepted pixel through the stage-1 and output registers
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without a pixel accepted two cycles earlier");

endmodule

bind rgb_box_downsample_2x2 rbd_checker u_rbd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_red_out  (out_red_out),
  .out_green_out(out_green_out),
  .out_blue_out (out_blue_out),
  .out_frame_end(out_frame_end)
);

### test/rgb_box_downsample_2x2_test.sv
// Self-checking testbench for the 2x2 RGB box-filter downsampler.
module rgb_box_downsample_2x2_test;

  localparam logic [rbd_pkg::CFG_IDX_W-1:0] REG_SPARE = rbd_pkg::CFG_IDX_W'(2);
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_PIXELS = 950;

  typedef struct packed {
    rbd_pkg::pixel_t avg;
    logic            frame_end;
  } mip_pixel_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rbd_pkg::SIZE_W-1:0]    cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_red_in;
  logic [7:0]                    in_green_in;
  logic [7:0]                    in_blue_in;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_red_out;
  logic [7:0]                    out_green_out;
  logic [7:0]                    out_blue_out;
  logic                          out_frame_end;

  rgb_box_downsample_2x2 dut (.*);

  logic [rbd_pkg::SIZE_W-1:0] width_reg;
  logic [rbd_pkg::SIZE_W-1:0] height_reg;
  int unsigned                col_pos;
  int unsigned                row_pos;
  rbd_pkg::pixel_t            held_pixel;
  rbd_pkg::pair_sum_t         upper_sums [rbd_pkg::LINE_DEPTH];
  mip_pixel_t                 expected_pixels [$];
  int                         errors;
  int                         in_idle_max;
  int                         out_idle_max;
  int                         result_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("rgb_box_downsample_2x2_test: errors");
    $finish;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return clamp_size(32'(width_reg), rbd_pkg::MAX_WIDTH) *
           clamp_size(32'(height_reg), rbd_pkg::MAX_HEIGHT);
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 18;
      default: return $urandom_range(1, 18);
    endcase
  endfunction

  function automatic void box_filter_step(rbd_pkg::pixel_t px);
    int unsigned               w, h, c, r;
    logic [rbd_pkg::IDX_W-1:0] idx;
    rbd_pkg::pair_sum_t        lower;
    rbd_pkg::pair_sum_t        upper;
    logic [9:0]                tr, tg, tb;
    mip_pixel_t                res;
    w = clamp_size(32'(width_reg), rbd_pkg::MAX_WIDTH);
    h = clamp_size(32'(height_reg), rbd_pkg::MAX_HEIGHT);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    if (c % 2 == 0) begin
      if (c + 1 < w) held_pixel = px;
    end else begin
      idx = rbd_pkg::IDX_W'(c / 2);
      lower.r = 9'(held_pixel.r) + 9'(px.r);
      lower.g = 9'(held_pixel.g) + 9'(px.g);
      lower.b = 9'(held_pixel.b) + 9'(px.b);
      if (r % 2 == 0) begin
        upper_sums[idx] = lower;
      end else begin
        upper = upper_sums[idx];
        tr = 10'(upper.r) + 10'(lower.r);
        tg = 10'(upper.g) + 10'(lower.g);
        tb = 10'(upper.b) + 10'(lower.b);
        res.avg.r = tr[9:2];
        res.avg.g = tg[9:2];
        res.avg.b = tb[9:2];
        res.frame_end = (c / 2 == w / 2 - 1) && (r / 2 == h / 2 - 1);
        expected_pixels.push_back(res);
      end
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    mip_pixel_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_hold = $urandom_range(0, out_idle_max);
      if (expected_pixels.size() == 0) begin
        $error("result word with none expected");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out", want.avg.r, out_red_out);
        check_field("green_out", want.avg.g, out_green_out);
        check_field("blue_out", want.avg.b, out_blue_out);
        check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (result_hold > 0) begin
        out_stall <= 1'b1;
        result_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(input rbd_pkg::pixel_t px);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_red_in   <= px.r;
    in_green_in <= px.g;
    in_blue_in  <= px.b;
    do @(posedge clk); while (in_stall !== 1'b0);
    box_filter_step(px);
  endtask

  task automatic send_random_pixels(input int unsigned n);
    repeat (n) send_pixel(24'($urandom));
  endtask

  // wait out every expected word plus the pipeline tail
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [rbd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rbd_pkg::SIZE_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rbd_pkg::REG_SOURCE_WIDTH) begin
      width_reg = value;
      col_pos = 0;
      row_pos = 0;
    end else if (idx == rbd_pkg::REG_SOURCE_HEIGHT) begin
      height_reg = value;
      col_pos = 0;
      row_pos = 0;
    end
  endtask

  task automatic set_size(input logic [rbd_pkg::SIZE_W-1:0] w,
                          input logic [rbd_pkg::SIZE_W-1:0] h);
    write_register(rbd_pkg::REG_SOURCE_WIDTH, w);
    write_register(rbd_pkg::REG_SOURCE_HEIGHT, h);
  endtask

  // full-scale channels, truncation, back-to-back frames
  task automatic test_pixel_extremes();
    in_idle_max = 0;
    out_idle_max = 0;
    set_size(12'd2, 12'd2);
    repeat (3) send_pixel({8'd255, 8'd0, 8'd1});
    send_pixel({8'd255, 8'd0, 8'd2});
    repeat (3) send_pixel({8'd0, 8'd255, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd254});
  endtask

  task automatic test_odd_sizes();
    in_idle_max = 18;
    out_idle_max = 18;
    set_size(12'd3, 12'd3);
    send_random_pixels(9);
  endtask

  task automatic test_undersize_clamp();
    set_size(12'd1, 12'd0);
    send_random_pixels(4);
  endtask

  // spare index keeps the position, a real write restarts it
  task automatic test_config_restart();
    set_size(12'd2, 12'd2);
    send_random_pixels(2);
    drain();
    write_register(REG_SPARE, 12'hFFF);
    send_random_pixels(2);
    send_random_pixels(3);
    write_register(rbd_pkg::REG_SOURCE_WIDTH, 12'd2);
    send_random_pixels(4);
  endtask

  task automatic test_size_limits();
    in_idle_max = 2;
    out_idle_max = 2;
    set_size(12'hFFF, 12'd2);
    send_random_pixels(40);
    set_size(12'd2, 12'd2049);
    send_random_pixels(40);
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, h, n, split;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      in_idle_max = pick_idle();
      out_idle_max = pick_idle();
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 1);
        1: w = $urandom_range(17, 40);
        default: w = $urandom_range(2, 12);
      endcase
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
      case ($urandom_range(0, 3))
        0: write_register(rbd_pkg::REG_SOURCE_WIDTH, rbd_pkg::SIZE_W'(w));
        1: write_register(rbd_pkg::REG_SOURCE_HEIGHT, rbd_pkg::SIZE_W'(h));
        default: set_size(rbd_pkg::SIZE_W'(w), rbd_pkg::SIZE_W'(h));
      endcase
      if ($urandom_range(0, 7) == 0) write_register(REG_SPARE, 12'($urandom));
      repeat ($urandom_range(1, 3)) begin
        n = frame_pixels();
        if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
        split = $urandom_range(0, n);
        send_random_pixels(split);
        if ($urandom_range(0, 7) == 0) drain();
        send_random_pixels(n - split);
        sent += n;
      end
    end
  endtask

  initial begin
    errors       = 0;
    result_hold  = 0;
    in_idle_max  = 0;
    out_idle_max = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = rbd_pkg::REG_SOURCE_WIDTH;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_red_in    = '0;
    in_green_in  = '0;
    in_blue_in   = '0;
    width_reg    = 12'd2;
    height_reg   = 12'd2;
    col_pos      = 0;
    row_pos      = 0;
    held_pixel   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_pixel_extremes();
    test_odd_sizes();
    test_undersize_clamp();
    test_config_restart();
    test_size_limits();
    test_random_frames();

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("rgb_box_downsample_2x2_test: clean");
    end else begin
      $display("rgb_box_downsample_2x2_test: errors");
    end
    $finish;
  end

endmodule
